// ===== hw/rtl/tsrp_pkg.sv =====
package tsrp_pkg;

    // Timing and fixed point
    localparam int TICK_PER_SECOND = 1000;
    localparam int RATE_FRAC_BITS  = 10;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int HZ_W    = 16;
    localparam int STEP_W  = 24;
    localparam int ACCEL_W = 20;
    localparam int POS_W   = 32;
    localparam int INC_W   = 20;
    localparam int RATE_W  = HZ_W + RATE_FRAC_BITS;

    localparam logic [INC_W-1:0] INC_MAX = '1;

    // Rate increment = round(accel * 2^F / TICK_PER_SECOND), done as an exact
    // multiply by a rounded-up reciprocal (numerator below 2^NUM_W)
    localparam int NUM_W       = ACCEL_W + RATE_FRAC_BITS + 1;
    localparam int RECIP_SHIFT = NUM_W + $clog2(TICK_PER_SECOND);
    localparam int RECIP_W     = NUM_W + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(TICK_PER_SECOND) - 64'd1) / 64'(TICK_PER_SECOND);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_FULL[RECIP_W-1:0];
    localparam logic [NUM_W-1:0]   HALF_TICK = NUM_W'(TICK_PER_SECOND / 2);

    // Braking test products
    localparam int LHS_W = ACCEL_W + POS_W;
    localparam int SQ_W  = 2 * RATE_W;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SETPOS = 2'd3;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 2'd2;
    localparam logic [HZ_W-1:0] START_SPEED_RST = 16'd200;
    localparam logic [HZ_W-1:0] MIN_SPEED_RST   = 16'd50;
    localparam logic [HZ_W-1:0] MAX_SPEED_RST   = 16'd19500;

    typedef enum logic [1:0] {
        OP_START,
        OP_EDGE,
        OP_TICK,
        OP_SETPOS
    } tsrp_op_t;

    // Classified request as held in the queue
    typedef struct packed {
        tsrp_op_t                  op;
        logic                      start_bad;
        logic                      forward;
        logic [STEP_W-1:0]         step_count;
        logic [HZ_W-1:0]           target_speed_hz;
        logic [ACCEL_W-1:0]        accel_rate;
        logic                      accel_zero;
        logic [INC_W-1:0]          rate_inc;
        logic signed [POS_W-1:0]   new_position;
    } tsrp_item_t;

    typedef struct packed {
        logic [HZ_W-1:0] start_speed_hz;
        logic [HZ_W-1:0] min_speed_hz;
        logic [HZ_W-1:0] max_speed_hz;
    } tsrp_cfg_t;

    typedef struct packed {
        logic [HZ_W-1:0]         step_rate_hz;
        logic                    dir_out;
        logic                    moving;
        logic                    move_done;
        logic                    rejected;
        logic signed [POS_W-1:0] position_count;
    } tsrp_result_t;

endpackage

// ===== hw/rtl/tsrp_front.sv =====
module tsrp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tsrp_pkg::CMD_W-1:0]       in_cmd,
    input  logic [tsrp_pkg::STEP_W-1:0]      in_step_count,
    input  logic [tsrp_pkg::HZ_W-1:0]        in_target_speed_hz,
    input  logic [tsrp_pkg::ACCEL_W-1:0]     in_accel_rate,
    input  logic                             in_forward,
    input  logic signed [tsrp_pkg::POS_W-1:0] in_new_position,
    output logic                             out_valid,
    input  logic                             out_ready,
    output tsrp_pkg::tsrp_item_t             out_item
);
    import tsrp_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    tsrp_item_t         s1_item_reg;
    tsrp_item_t         s1_item_next;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [PROD_W-1:0]  s1_prod_next;

    logic               accept;
    tsrp_op_t           op_dec;
    logic [NUM_W-1:0]   inc_num;
    logic [PROD_W-1:0]  quot;

    assign in_ready = !s1_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Command decode
    always_comb
    begin
        unique case (in_cmd)
            CMD_START:  op_dec = OP_START;
            CMD_EDGE:   op_dec = OP_EDGE;
            CMD_TICK:   op_dec = OP_TICK;
            CMD_SETPOS: op_dec = OP_SETPOS;
            default:    op_dec = OP_SETPOS;
        endcase
    end

    // Increment numerator: accel scaled to rate units, plus half a tick for rounding
    assign inc_num = (NUM_W'(in_accel_rate) << RATE_FRAC_BITS) + HALF_TICK;

    // Stage register next values
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        s1_prod_next  = s1_prod_reg;
        if (accept)
        begin
            s1_valid_next                = 1'b1;
            s1_item_next.op              = op_dec;
            s1_item_next.start_bad       = (in_step_count == '0) ||
                                           (in_target_speed_hz == '0);
            s1_item_next.forward         = in_forward;
            s1_item_next.step_count      = in_step_count;
            s1_item_next.target_speed_hz = in_target_speed_hz;
            s1_item_next.accel_rate      = in_accel_rate;
            s1_item_next.accel_zero      = (in_accel_rate == '0);
            s1_item_next.rate_inc        = '0;
            s1_item_next.new_position    = in_new_position;
            s1_prod_next                 = PROD_W'(inc_num) * PROD_W'(RECIP);
        end
        else if (out_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s1_prod_reg <= s1_prod_next;
    end

    // Quotient from the reciprocal product, saturated to the increment width
    assign quot = s1_prod_reg >> RECIP_SHIFT;

    always_comb
    begin
        out_item = s1_item_reg;
        if (quot > PROD_W'(INC_MAX))
        begin
            out_item.rate_inc = INC_MAX;
        end
        else
        begin
            out_item.rate_inc = quot[INC_W-1:0];
        end
    end

    assign out_valid = s1_valid_reg;

endmodule

// ===== hw/rtl/tsrp_queue.sv =====
module tsrp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tsrp_pkg::tsrp_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tsrp_pkg::tsrp_item_t out_item
);
    import tsrp_pkg::*;

    tsrp_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hw/rtl/tsrp_back.sv =====
module tsrp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tsrp_pkg::tsrp_cfg_t    cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tsrp_pkg::tsrp_item_t   in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tsrp_pkg::tsrp_result_t out_result
);
    import tsrp_pkg::*;

    // Architectural state
    logic [POS_W-1:0]   position_reg,   position_next;
    logic [POS_W-1:0]   target_reg,     target_next;
    logic [POS_W-1:0]   diff_reg,       diff_next;
    logic [POS_W-1:0]   rem_reg,        rem_next;
    logic [RATE_W-1:0]  rate_reg,       rate_next;
    logic [HZ_W-1:0]    cruise_reg,     cruise_next;
    logic [ACCEL_W-1:0] accel_reg,      accel_next;
    logic [INC_W-1:0]   inc_reg,        inc_next;
    logic               dir_reg,        dir_next;
    logic               running_reg,    running_next;

    // Braking test products, registered from the state so that they lag it
    logic [LHS_W-1:0]   lhs_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic               fresh_reg;

    // Result register
    logic               res_valid_reg;
    logic [HZ_W-1:0]    res_hz_reg;
    logic               res_dir_reg;
    logic               res_moving_reg;
    logic               res_done_reg;
    logic               res_rej_reg;
    logic [POS_W-1:0]   res_pos_reg;

    logic               exec;
    logic               done_now;
    logic               rej_now;
    logic               at_target;
    logic               brake;
    logic [POS_W-1:0]   steps_ext;
    logic [RATE_W-1:0]  floor_fx;
    logic [RATE_W-1:0]  cruise_fx;
    logic [RATE_W-1:0]  max_fx;
    logic [RATE_W:0]    floor_plus;
    logic [RATE_W:0]    rate_plus;
    logic [RATE_W-1:0]  rate_step;
    logic [HZ_W-1:0]    hz_lo;

    // A tick needs products of the settled state
    assign exec     = in_valid && (!res_valid_reg || out_ready) &&
                      ((in_item.op != OP_TICK) || fresh_reg);
    assign in_ready = exec;

    assign steps_ext = POS_W'(in_item.step_count);
    assign floor_fx  = RATE_W'(cfg.start_speed_hz) << RATE_FRAC_BITS;
    assign cruise_fx = RATE_W'(cruise_reg) << RATE_FRAC_BITS;
    assign max_fx    = RATE_W'(cfg.max_speed_hz) << RATE_FRAC_BITS;

    // Target reached: forward when diff >= 0, reverse when diff <= 0
    assign at_target = dir_reg ? !diff_reg[POS_W-1]
                               : (diff_reg[POS_W-1] || (diff_reg == '0));

    // 2 * accel * remaining <= rate^2
    assign brake = ({lhs_reg, 1'b0} <= (LHS_W + 1)'(sq_reg >> (2 * RATE_FRAC_BITS)));

    // Rate step of a tick that does not end the move
    always_comb
    begin
        floor_plus = (RATE_W + 1)'(floor_fx) + (RATE_W + 1)'(inc_reg);
        rate_plus  = (RATE_W + 1)'(rate_reg) + (RATE_W + 1)'(inc_reg);
        if (brake)
        begin
            if ((RATE_W + 1)'(rate_reg) < floor_plus)
            begin
                rate_step = floor_fx;
            end
            else
            begin
                rate_step = rate_reg - RATE_W'(inc_reg);
            end
        end
        else if (rate_reg < cruise_fx)
        begin
            if (rate_plus > (RATE_W + 1)'(cruise_fx))
            begin
                rate_step = cruise_fx;
            end
            else
            begin
                rate_step = rate_plus[RATE_W-1:0];
            end
        end
        else
        begin
            rate_step = cruise_fx;
        end
        if (rate_step > max_fx)
        begin
            rate_step = max_fx;
        end
    end

    // Request execution
    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        diff_next     = diff_reg;
        rem_next      = rem_reg;
        rate_next     = rate_reg;
        cruise_next   = cruise_reg;
        accel_next    = accel_reg;
        inc_next      = inc_reg;
        dir_next      = dir_reg;
        running_next  = running_reg;
        done_now      = 1'b0;
        rej_now       = 1'b0;
        if (exec)
        begin
            unique case (in_item.op)
                OP_START:
                begin
                    if (in_item.start_bad || running_reg)
                    begin
                        rej_now = 1'b1;
                    end
                    else
                    begin
                        target_next  = in_item.forward ? position_reg + steps_ext
                                                       : position_reg - steps_ext;
                        diff_next    = in_item.forward ? '0 - steps_ext : steps_ext;
                        rem_next     = steps_ext;
                        dir_next     = in_item.forward;
                        running_next = 1'b1;
                        cruise_next  = in_item.target_speed_hz;
                        accel_next   = in_item.accel_rate;
                        inc_next     = in_item.rate_inc;
                        rate_next    = in_item.accel_zero
                            ? RATE_W'(in_item.target_speed_hz) << RATE_FRAC_BITS
                            : floor_fx;
                    end
                end
                OP_EDGE:
                begin
                    position_next = dir_reg ? position_reg + 1'b1 : position_reg - 1'b1;
                    diff_next     = dir_reg ? diff_reg + 1'b1 : diff_reg - 1'b1;
                    rem_next      = rem_reg - 1'b1;
                end
                OP_TICK:
                begin
                    if (running_reg)
                    begin
                        if (at_target)
                        begin
                            running_next = 1'b0;
                            rate_next    = '0;
                            done_now     = 1'b1;
                        end
                        else if (accel_reg != '0)
                        begin
                            rate_next = rate_step;
                        end
                    end
                end
                OP_SETPOS:
                begin
                    position_next = POS_W'(in_item.new_position);
                    diff_next     = POS_W'(in_item.new_position) - target_reg;
                    rem_next      = dir_reg ? target_reg - POS_W'(in_item.new_position)
                                            : POS_W'(in_item.new_position) - target_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            target_reg    <= '0;
            diff_reg      <= '0;
            rem_reg       <= '0;
            rate_reg      <= '0;
            cruise_reg    <= '0;
            accel_reg     <= '0;
            inc_reg       <= '0;
            dir_reg       <= 1'b1;
            running_reg   <= 1'b0;
            fresh_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            position_reg  <= position_next;
            target_reg    <= target_next;
            diff_reg      <= diff_next;
            rem_reg       <= rem_next;
            rate_reg      <= rate_next;
            cruise_reg    <= cruise_next;
            accel_reg     <= accel_next;
            inc_reg       <= inc_next;
            dir_reg       <= dir_next;
            running_reg   <= running_next;
            fresh_reg     <= !exec;
            if (exec)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Products and result payload
    always_ff @(posedge clk)
    begin
        lhs_reg <= LHS_W'(accel_reg) * LHS_W'(rem_reg);
        sq_reg  <= SQ_W'(rate_reg) * SQ_W'(rate_reg);
        if (exec)
        begin
            res_hz_reg     <= rate_next[RATE_W-1:RATE_FRAC_BITS];
            res_dir_reg    <= dir_next;
            res_moving_reg <= running_next;
            res_done_reg   <= done_now;
            res_rej_reg    <= rej_now;
            res_pos_reg    <= position_next;
        end
    end

    // Output rate: zero when stopped or paused, else min clamp then max clamp
    always_comb
    begin
        hz_lo = (res_hz_reg < cfg.min_speed_hz) ? cfg.min_speed_hz : res_hz_reg;
        if (!res_moving_reg || (res_hz_reg == '0))
        begin
            out_result.step_rate_hz = '0;
        end
        else if (hz_lo > cfg.max_speed_hz)
        begin
            out_result.step_rate_hz = cfg.max_speed_hz;
        end
        else
        begin
            out_result.step_rate_hz = hz_lo;
        end
        out_result.dir_out        = res_dir_reg;
        out_result.moving         = res_moving_reg;
        out_result.move_done      = res_done_reg;
        out_result.rejected       = res_rej_reg;
        out_result.position_count = res_pos_reg;
    end

    assign out_valid = res_valid_reg;

endmodule

// ===== hw/rtl/trapezoid_step_rate_profiler_core.sv =====
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  s_tuser command, s_tdata move fields
// m_*      out        m_tvalid / m_tready  m_tdata step rate, flags, position
// cfg_*    in         cfg_wr_en            cfg_index, cfg_wdata (16 bit speeds)
//
// One request per cycle while m_tready allows, except that a tick is held when
// the back end executed a request in the cycle before: its braking test reads
// the registered accel*distance and rate^2 products, which lag the motion state.
// A request passes the front stage, the queue and the result register in that
// order before it reaches m_tdata.
// Reset clears control and motion state at once; there is no clearing pass.
// m_tready low holds the result; the four-entry queue then fills and
// s_tready falls once the queue and the front stage are both full.
module trapezoid_step_rate_profiler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [23:0] step_count, [39:24] target_speed_hz, [59:40] accel_rate,
    // [60] forward, [92:61] new_position, [95:93] zero
    input  logic [95:0]                        s_tdata,
    // [1:0] cmd
    input  logic [tsrp_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] step_rate_hz, [16] dir_out, [17] moving, [18] move_done,
    // [19] rejected, [51:20] position_count, [55:52] zero
    output logic [55:0]                        m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [tsrp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsrp_pkg::HZ_W-1:0]          cfg_wdata
);
    import tsrp_pkg::*;

    tsrp_cfg_t    cfg_reg;
    tsrp_cfg_t    cfg_next;
    tsrp_item_t   front_item;
    tsrp_item_t   queue_item;
    tsrp_result_t result;
    logic         front_valid;
    logic         front_ready;
    logic         queue_valid;
    logic         queue_ready;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_START_SPEED: cfg_next.start_speed_hz = cfg_wdata;
                CFG_MIN_SPEED:   cfg_next.min_speed_hz   = cfg_wdata;
                CFG_MAX_SPEED:   cfg_next.max_speed_hz   = cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_speed_hz <= START_SPEED_RST;
            cfg_reg.min_speed_hz   <= MIN_SPEED_RST;
            cfg_reg.max_speed_hz   <= MAX_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Decode and rate increment
    tsrp_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .in_cmd             (s_tuser),
        .in_step_count      (s_tdata[23:0]),
        .in_target_speed_hz (s_tdata[39:24]),
        .in_accel_rate      (s_tdata[59:40]),
        .in_forward         (s_tdata[60]),
        .in_new_position    ($signed(s_tdata[92:61])),
        .out_valid          (front_valid),
        .out_ready          (front_ready),
        .out_item           (front_item)
    );

    // Request queue
    tsrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    // Motion state and result
    tsrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {4'b0000, result.position_count, result.rejected, result.move_done,
                      result.moving, result.dir_out, result.step_rate_hz};

endmodule
